[hdl/keyed_multi_stack_engine_assert.svh]
// Assertion macros for the keyed multi-stack engine.
// Used by the top level; needs nothing but a clock and an active-low reset.
`ifndef KEYED_MULTI_STACK_ENGINE_ASSERT_SVH
`define KEYED_MULTI_STACK_ENGINE_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define KMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_multi_stack_engine: same-cycle check failed");

// Next-cycle implication, off while in reset.
`define KMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_multi_stack_engine: next-cycle check failed");

`endif

[hdl/kms_pkg.sv]
// Shared types and constants for the keyed multi-stack engine.
// No dependencies.
package kms_pkg;

    localparam int TYPE_SLOTS_DEF = 8;
    localparam int POOL_DEPTH_DEF = 64;
    localparam int ITEM_BITS_DEF  = 32;

    localparam int TYPE_W   = 8;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic val_we;
        logic link_we;
    } t_pool_we;

endpackage

[hdl/keyed_multi_stack_engine.sv]
// Keyed multi-stack engine top level: type-slot table, pointers and request control.
// Uses kms_pkg, kms_pool and keyed_multi_stack_engine_assert.svh.
//
// One request per clock while busy is low: busy is set in reset and cleared by the clock
// once reset is released, and a request is taken whenever start is high and busy is low.
// Each request waits in a request register and is resolved into the result register
// behind o_valid, o_popped_item and o_status; the result stays for one cycle only and the
// receiver cannot stall it. The pool's read port is registered: the entry a request needs
// is read in the accept cycle from the pointers as the previous request leaves them, and
// the request is resolved and written back in the next cycle. No clearing pass after reset.
`include "keyed_multi_stack_engine_assert.svh"

module keyed_multi_stack_engine #(
    parameter int TYPE_SLOTS = kms_pkg::TYPE_SLOTS_DEF,
    parameter int POOL_DEPTH = kms_pkg::POOL_DEPTH_DEF,
    parameter int ITEM_BITS  = kms_pkg::ITEM_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_kind,
    input  logic [kms_pkg::TYPE_W-1:0]   i_type_code,
    input  logic [kms_pkg::ITEM_W-1:0]   i_item,
    output logic                         o_valid,
    output logic [kms_pkg::ITEM_W-1:0]   o_popped_item,
    output logic [kms_pkg::STATUS_W-1:0] o_status
);

    localparam int SLOT_W = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int PTR_W  = $clog2(POOL_DEPTH+1);
    localparam int ITEM_W = kms_pkg::ITEM_W;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

    // slot table and pool pointers
    logic                       r_slot_used [TYPE_SLOTS];
    logic [kms_pkg::TYPE_W-1:0] r_slot_type [TYPE_SLOTS];
    logic [PTR_W-1:0]           r_stack_top [TYPE_SLOTS];
    logic [PTR_W-1:0]           r_free_head;
    logic [PTR_W-1:0]           r_never;
    logic                       n_slot_used [TYPE_SLOTS];
    logic [kms_pkg::TYPE_W-1:0] n_slot_type [TYPE_SLOTS];
    logic [PTR_W-1:0]           n_stack_top [TYPE_SLOTS];
    logic [PTR_W-1:0]           n_free_head;
    logic [PTR_W-1:0]           n_never;

    // request register
    logic                       r_busy;
    logic                       r_s1_valid;
    logic                       r_s1_kind;
    logic [kms_pkg::TYPE_W-1:0] r_s1_type;
    logic [ITEM_BITS-1:0]       r_s1_item;

    // result register
    logic                       r_out_valid;
    logic [ITEM_W-1:0]          r_out_item;
    kms_pkg::t_status           r_out_status;
    logic [ITEM_W-1:0]          n_out_item;
    kms_pkg::t_status           n_out_status;

    // pool access
    kms_pkg::t_pool_we          pool_we;
    logic [IDX_W-1:0]           wr_addr;
    logic [PTR_W-1:0]           wr_link;
    logic [IDX_W-1:0]           rd_addr;
    logic [ITEM_BITS-1:0]       rd_val;
    logic [PTR_W-1:0]           rd_link;

    logic                       accept;
    logic                       s0_hit;
    logic [SLOT_W-1:0]          s0_slot;
    logic [PTR_W-1:0]           rd_ptr;

    logic                       s1_hit;
    logic [SLOT_W-1:0]          s1_slot;
    logic                       s1_free;
    logic [SLOT_W-1:0]          s1_free_slot;
    logic [SLOT_W-1:0]          s1_tgt;
    logic [PTR_W-1:0]           s1_entry;
    logic [PTR_W-1:0]           s1_top;
    logic                       have_entry;

    assign accept = start && !busy;
    assign busy   = r_busy;

    kms_pool #(
        .POOL_DEPTH (POOL_DEPTH),
        .ITEM_BITS  (ITEM_BITS)
    ) u_pool (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (pool_we),
        .i_wr_addr (wr_addr),
        .i_wr_val  (r_s1_item),
        .i_wr_link (wr_link),
        .i_rd_addr (rd_addr),
        .o_rd_val  (rd_val),
        .o_rd_link (rd_link)
    );

    // resolve the registered request against the current tables
    always_comb begin
        s1_hit       = 1'b0;
        s1_slot      = '0;
        s1_free      = 1'b0;
        s1_free_slot = '0;
        for (int k = 0; k < TYPE_SLOTS; k++) begin
            if (!s1_hit && r_slot_used[k] && (r_slot_type[k] == r_s1_type)) begin
                s1_hit  = 1'b1;
                s1_slot = SLOT_W'(k);
            end
            if (!s1_free && !r_slot_used[k]) begin
                s1_free      = 1'b1;
                s1_free_slot = SLOT_W'(k);
            end
        end
        s1_tgt     = s1_hit ? s1_slot : s1_free_slot;
        s1_top     = r_stack_top[s1_slot];
        have_entry = (r_free_head != NULL_PTR) || (r_never != NULL_PTR);
        s1_entry   = (r_free_head != NULL_PTR) ? r_free_head : r_never;

        n_slot_used  = r_slot_used;
        n_slot_type  = r_slot_type;
        n_stack_top  = r_stack_top;
        n_free_head  = r_free_head;
        n_never      = r_never;
        n_out_item   = '0;
        n_out_status = kms_pkg::ST_DONE;
        pool_we      = '0;
        wr_addr      = s1_entry[IDX_W-1:0];
        wr_link      = s1_hit ? s1_top : NULL_PTR;

        if (r_s1_valid) begin
            if (r_s1_kind == kms_pkg::KIND_PUSH) begin
                if ((s1_hit || s1_free) && have_entry) begin
                    if (!s1_hit) begin
                        n_slot_used[s1_tgt] = 1'b1;
                        n_slot_type[s1_tgt] = r_s1_type;
                    end
                    if (r_free_head != NULL_PTR) begin
                        n_free_head = rd_link;
                    end else begin
                        n_never = r_never + 1'b1;
                    end
                    n_stack_top[s1_tgt] = s1_entry;
                    pool_we.val_we      = 1'b1;
                    pool_we.link_we     = 1'b1;
                end else begin
                    n_out_status = kms_pkg::ST_FULL;
                end
            end else begin
                if (s1_hit && (s1_top != NULL_PTR)) begin
                    n_out_item           = ITEM_W'(rd_val);
                    n_stack_top[s1_slot] = rd_link;
                    n_free_head          = s1_top;
                    wr_addr              = s1_top[IDX_W-1:0];
                    wr_link              = r_free_head;
                    pool_we.link_we      = 1'b1;
                end else begin
                    n_out_status = kms_pkg::ST_EMPTY;
                end
            end
        end
    end

    // entry to read for the incoming request, from the tables as they will stand
    always_comb begin
        s0_hit  = 1'b0;
        s0_slot = '0;
        for (int k = 0; k < TYPE_SLOTS; k++) begin
            if (!s0_hit && n_slot_used[k] && (n_slot_type[k] == i_type_code)) begin
                s0_hit  = 1'b1;
                s0_slot = SLOT_W'(k);
            end
        end
        if (i_kind == kms_pkg::KIND_POP) begin
            rd_ptr = s0_hit ? n_stack_top[s0_slot] : NULL_PTR;
        end else begin
            rd_ptr = n_free_head;
        end
        rd_addr = (rd_ptr != NULL_PTR) ? rd_ptr[IDX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        r_slot_type <= n_slot_type;
        r_stack_top <= n_stack_top;
        r_s1_kind   <= i_kind;
        r_s1_type   <= i_type_code;
        r_s1_item   <= ITEM_BITS'(i_item);
        r_out_item  <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TYPE_SLOTS; k++) begin
                r_slot_used[k] <= 1'b0;
            end
            r_free_head  <= NULL_PTR;
            r_never      <= '0;
            r_busy       <= 1'b1;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_status <= kms_pkg::ST_DONE;
        end else begin
            r_slot_used  <= n_slot_used;
            r_free_head  <= n_free_head;
            r_never      <= n_never;
            r_busy       <= 1'b0;
            r_s1_valid   <= accept;
            r_out_valid  <= r_s1_valid;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_popped_item = r_out_item;
    assign o_status      = r_out_status;

    `KMS_ASSERT_NXT(a_accept_loads_request, i_clk, i_rst_n, accept, r_s1_valid)
    `KMS_ASSERT_NXT(a_request_gives_result, i_clk, i_rst_n, r_s1_valid, o_valid)
    `KMS_ASSERT_NOW(a_fail_returns_zero, i_clk, i_rst_n, o_valid && (o_status != kms_pkg::ST_DONE), o_popped_item == '0)
    `KMS_ASSERT_NOW(a_counter_in_range, i_clk, i_rst_n, 1'b1, (r_never <= NULL_PTR) && (r_free_head <= NULL_PTR))
    `KMS_ASSERT_NOW(a_push_claims_entry, i_clk, i_rst_n, pool_we.val_we, !have_entry == 1'b0)

endmodule

[hdl/kms_pool.sv]
// Shared entry pool: item values and links, one write and one registered read per cycle.
// Forwards a write to a read of the same entry in the same cycle. Uses kms_pkg.
module kms_pool #(
    parameter int POOL_DEPTH = kms_pkg::POOL_DEPTH_DEF,
    parameter int ITEM_BITS  = kms_pkg::ITEM_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kms_pkg::t_pool_we               i_we,
    input  logic [$clog2(POOL_DEPTH)-1:0]   i_wr_addr,
    input  logic [ITEM_BITS-1:0]            i_wr_val,
    input  logic [$clog2(POOL_DEPTH+1)-1:0] i_wr_link,
    input  logic [$clog2(POOL_DEPTH)-1:0]   i_rd_addr,
    output logic [ITEM_BITS-1:0]            o_rd_val,
    output logic [$clog2(POOL_DEPTH+1)-1:0] o_rd_link
);

    localparam int PTR_W = $clog2(POOL_DEPTH+1);

    logic [ITEM_BITS-1:0] mem_val  [POOL_DEPTH];
    logic [PTR_W-1:0]     mem_link [POOL_DEPTH];

    logic [ITEM_BITS-1:0] r_rd_val;
    logic [PTR_W-1:0]     r_rd_link;
    logic                 r_fwd_val;
    logic                 r_fwd_link;
    logic [ITEM_BITS-1:0] r_fwd_val_data;
    logic [PTR_W-1:0]     r_fwd_link_data;
    logic                 same_addr;

    assign same_addr = (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_we.val_we) begin
            mem_val[i_wr_addr] <= i_wr_val;
        end
        if (i_we.link_we) begin
            mem_link[i_wr_addr] <= i_wr_link;
        end
        r_rd_val        <= mem_val[i_rd_addr];
        r_rd_link       <= mem_link[i_rd_addr];
        r_fwd_val_data  <= i_wr_val;
        r_fwd_link_data <= i_wr_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_val  <= 1'b0;
            r_fwd_link <= 1'b0;
        end else begin
            r_fwd_val  <= i_we.val_we && same_addr;
            r_fwd_link <= i_we.link_we && same_addr;
        end
    end

    assign o_rd_val  = r_fwd_val  ? r_fwd_val_data  : r_rd_val;
    assign o_rd_link = r_fwd_link ? r_fwd_link_data : r_rd_link;

endmodule
